// ----- rtl/core/mmie_pkg.sv -----
// shared types, op codes and helper functions of the instruction executor
`timescale 1ns / 1ps

package mmie_pkg;

    // memory depth must be a power of two, addresses wrap by keeping the low bits
    localparam int MEM_WORDS   = 1024;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_BITS   = $clog2(MEM_WORDS);
    localparam int PC_BITS     = 10;
    localparam int OPA_BITS    = 32;
    localparam int OPB_BITS    = 10;
    localparam int OUT_BITS    = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] OP_SET       = 4'd0;
    localparam logic [3:0] OP_COPY      = 4'd1;
    localparam logic [3:0] OP_COPY_ISRC = 4'd2;
    localparam logic [3:0] OP_ADD_IMM   = 4'd3;
    localparam logic [3:0] OP_ADD       = 4'd4;
    localparam logic [3:0] OP_SUB       = 4'd5;
    localparam logic [3:0] OP_JUMP_LE   = 4'd6;
    localparam logic [3:0] OP_COPY_IDST = 4'd7;
    localparam logic [3:0] OP_HALT      = 4'd8;
    localparam logic [3:0] OP_LOAD      = 4'd9;
    localparam logic [3:0] OP_READ      = 4'd10;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef struct packed {
        logic [3:0]                 op;
        logic signed [OPA_BITS-1:0] operand_a;
        logic [OPB_BITS-1:0]        operand_b;
    } in_t;

    typedef struct packed {
        logic [PC_BITS-1:0]         next_pc;
        logic                       halted;
        logic signed [OUT_BITS-1:0] read_value;
    } out_t;

    typedef enum logic [3:0] {
        K_NOP,
        K_LOAD,
        K_READ,
        K_SET,
        K_COPY,
        K_COPY_ISRC,
        K_ADD_IMM,
        K_ADD,
        K_SUB,
        K_JUMP_LE,
        K_COPY_IDST,
        K_HALT
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        addr_t              addr_a;
        addr_t              addr_b;
        word_t              imm;
        logic [PC_BITS-1:0] target;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR
    } state_t;

    // instructions that the halt flag blocks
    function automatic logic is_exec(input kind_t k);
        logic r;
        case (k) inside
            K_SET, K_COPY, K_COPY_ISRC, K_ADD_IMM, K_ADD, K_SUB,
            K_JUMP_LE, K_COPY_IDST, K_HALT: r = 1'b1;
            default:                         r = 1'b0;
        endcase
        return r;
    endfunction

    // two's complement word to address, negative values count back from the top
    function automatic addr_t word_to_addr(input word_t w);
        logic [ADDR_BITS+WORD_BITS-1:0] ext;
        ext = {{ADDR_BITS{w[WORD_BITS-1]}}, w};
        return ext[ADDR_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/mmie_front.sv -----
// front end: classifies a request and prepares its addresses and immediate
`timescale 1ns / 1ps

module mmie_front (
    input  mmie_pkg::in_t  req,
    output mmie_pkg::cmd_t cmd
);
    import mmie_pkg::*;

    logic [ADDR_BITS+OPA_BITS-1:0]  a_ext;
    logic [ADDR_BITS+OPB_BITS-1:0]  b_ext;
    logic [WORD_BITS+OPA_BITS-1:0]  imm_ext;

    always_comb
    begin
        a_ext   = {{ADDR_BITS{req.operand_a[OPA_BITS-1]}}, req.operand_a};
        b_ext   = {{ADDR_BITS{1'b0}}, req.operand_b};
        imm_ext = {{WORD_BITS{req.operand_a[OPA_BITS-1]}}, req.operand_a};

        cmd.addr_a = a_ext[ADDR_BITS-1:0];
        cmd.addr_b = b_ext[ADDR_BITS-1:0];
        cmd.imm    = imm_ext[WORD_BITS-1:0];
        cmd.target = req.operand_b;

        unique case (req.op)
            OP_SET:       cmd.kind = K_SET;
            OP_COPY:      cmd.kind = K_COPY;
            OP_COPY_ISRC: cmd.kind = K_COPY_ISRC;
            OP_ADD_IMM:   cmd.kind = K_ADD_IMM;
            OP_ADD:       cmd.kind = K_ADD;
            OP_SUB:       cmd.kind = K_SUB;
            OP_JUMP_LE:   cmd.kind = K_JUMP_LE;
            OP_COPY_IDST: cmd.kind = K_COPY_IDST;
            OP_HALT:      cmd.kind = K_HALT;
            OP_LOAD:      cmd.kind = K_LOAD;
            OP_READ:      cmd.kind = K_READ;
            default:      cmd.kind = K_NOP;
        endcase
    end

endmodule

// ----- rtl/core/mmie_fifo.sv -----
// short command queue between the front end and the execution unit
`timescale 1ns / 1ps

module mmie_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mmie_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output mmie_pkg::cmd_t rdata,
    output logic           empty
);
    import mmie_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/core/mmie_back.sv -----
// execution unit: sequencer over the single-port data memory, pc, halt flag, result register
`timescale 1ns / 1ps

module mmie_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mmie_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output mmie_pkg::out_t out_data
);
    import mmie_pkg::*;

    word_t              mem [MEM_WORDS];

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    word_t              tmp_reg, tmp_next;
    word_t              rdata_reg;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               halt_reg, halt_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic               done;
    logic               jump_taken;
    kind_t              head_kind;
    logic               mem_re;
    logic               mem_we;
    addr_t              mem_addr;
    word_t              mem_wdata;

    function automatic state_t first_state(input kind_t k);
        state_t s;
        case (k) inside
            K_NOP, K_LOAD, K_SET, K_HALT: s = S_WR;
            default:                      s = S_RD1;
        endcase
        return s;
    endfunction

    function automatic logic [OUT_BITS-1:0] word_to_out(input word_t w);
        logic [OUT_BITS+WORD_BITS-1:0] ext;
        ext = {{OUT_BITS{w[WORD_BITS-1]}}, w};
        return ext[OUT_BITS-1:0];
    endfunction

    function automatic word_t target_word(input logic [PC_BITS-1:0] t);
        logic [WORD_BITS+PC_BITS-1:0] ext;
        ext = {{WORD_BITS{1'b0}}, t};
        return ext[WORD_BITS-1:0];
    endfunction

    // an instruction finishes once the result register can take its result
    assign done       = (state_reg == S_WR) && (!out_valid_reg || out_ready);
    assign pop        = head_valid && ((state_reg == S_IDLE) || done);
    assign jump_taken = (cmd_reg.kind == K_JUMP_LE)
                        && ((rdata_reg == '0) || rdata_reg[WORD_BITS-1]);
    assign halt_next  = halt_reg || (done && (cmd_reg.kind == K_HALT));
    // the halt decision of the finishing instruction applies to the one popped with it
    assign head_kind  = (is_exec(head.kind) && halt_next) ? K_NOP : head.kind;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = first_state(head_kind);
                end
            end
            S_RD1:
            begin
                case (cmd_reg.kind) inside
                    K_COPY_ISRC, K_ADD, K_SUB, K_COPY_IDST: state_next = S_RD2;
                    default:                                state_next = S_WR;
                endcase
            end
            S_RD2:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (done)
                begin
                    state_next = pop ? first_state(head_kind) : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory control, datapath and result
    always_comb
    begin
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = cmd_reg.addr_b;
        mem_wdata      = rdata_reg;
        tmp_next       = tmp_reg;
        pc_next        = pc_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_next       = cmd_reg;

        if (pop)
        begin
            cmd_next      = head;
            cmd_next.kind = head_kind;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                mem_re = 1'b0;
            end
            S_RD1:
            begin
                mem_re = 1'b1;
                case (cmd_reg.kind) inside
                    K_READ, K_ADD_IMM, K_COPY_IDST: mem_addr = cmd_reg.addr_b;
                    default:                        mem_addr = cmd_reg.addr_a;
                endcase
            end
            S_RD2:
            begin
                mem_re   = 1'b1;
                tmp_next = rdata_reg;
                case (cmd_reg.kind)
                    K_COPY_ISRC: mem_addr = word_to_addr(rdata_reg);
                    K_COPY_IDST: mem_addr = cmd_reg.addr_a;
                    default:     mem_addr = cmd_reg.addr_b;
                endcase
            end
            S_WR:
            begin
                case (cmd_reg.kind)
                    K_SET, K_LOAD:
                    begin
                        mem_we    = done;
                        mem_wdata = cmd_reg.imm;
                    end
                    K_COPY, K_COPY_ISRC:
                    begin
                        mem_we    = done;
                        mem_wdata = rdata_reg;
                    end
                    K_ADD_IMM:
                    begin
                        mem_we    = done;
                        mem_wdata = rdata_reg + cmd_reg.imm;
                    end
                    K_ADD:
                    begin
                        mem_we    = done;
                        mem_wdata = tmp_reg + rdata_reg;
                    end
                    K_SUB:
                    begin
                        mem_we    = done;
                        mem_wdata = tmp_reg - rdata_reg;
                    end
                    K_JUMP_LE:
                    begin
                        // taken jump also leaves its target in word 0
                        mem_we    = done && jump_taken;
                        mem_addr  = '0;
                        mem_wdata = target_word(cmd_reg.target);
                    end
                    K_COPY_IDST:
                    begin
                        mem_we    = done;
                        mem_addr  = word_to_addr(tmp_reg);
                        mem_wdata = rdata_reg;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase

                if (done)
                begin
                    case (cmd_reg.kind)
                        K_NOP, K_LOAD, K_READ, K_HALT: pc_next = pc_reg;
                        K_JUMP_LE: pc_next = jump_taken ? cmd_reg.target
                                                        : pc_reg + PC_BITS'(1);
                        default:   pc_next = pc_reg + PC_BITS'(1);
                    endcase
                    out_valid_next        = 1'b1;
                    out_data_next.next_pc = pc_next;
                    out_data_next.halted  = halt_next;
                    out_data_next.read_value = (cmd_reg.kind == K_READ)
                                               ? word_to_out(rdata_reg) : '0;
                end
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

endmodule

// ----- rtl/core/memory_to_memory_instruction_executor.sv -----
// set, load, halt and unused ops go straight to the write state S_WR; copy, add immediate,
// jump and read pass S_RD1 first; indirect copies, add and subtract pass S_RD1 and S_RD2;
// the result is registered on out_data and out_valid as the instruction leaves S_WR
// requests run one at a time over the single memory port; the queue holds those waiting
// reset: rst_n clears the program counter, halt flag, queue and result valid flag at once;
// the data memory is not cleared and reads as undefined until written
`timescale 1ns / 1ps

module memory_to_memory_instruction_executor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mmie_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mmie_pkg::out_t out_data
);
    import mmie_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign in_ready = !q_full;

    mmie_front u_front (
        .req (in_data),
        .cmd (front_cmd)
    );

    mmie_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_valid && in_ready),
        .wdata (front_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (head_cmd),
        .empty (q_empty)
    );

    mmie_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ----- rtl/core/mmie_checker.sv -----
// port-level checker of the instruction executor and its bind
`timescale 1ns / 1ps

module mmie_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input mmie_pkg::out_t out_data
);
    import mmie_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       seen_halt_reg, seen_halt_next;

    always_comb
    begin
        pending_next   = pending_reg;
        seen_halt_next = seen_halt_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pending_next = pending_reg - 1'b1;
        end
        if (out_valid && out_ready && out_data.halted)
        begin
            seen_halt_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            seen_halt_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            seen_halt_reg <= seen_halt_next;
        end
    end

    // a result needs a request that has not yet been answered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result without an outstanding request");

    // halt is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_halt_reg) |-> out_data.halted)
        else $error("halted flag dropped after a halt");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or withdrawn");

    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind memory_to_memory_instruction_executor mmie_checker u_mmie_checker (.*);

// ----- sim/tb_memory_to_memory_instruction_executor.sv -----
// self-checking testbench of the memory-to-memory instruction executor
`timescale 1ns / 1ps

module tb_memory_to_memory_instruction_executor;

    import mmie_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b1;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // machine state as the executor should hold it
    word_t              mem_model [MEM_WORDS];
    bit                 word_valid [MEM_WORDS];
    addr_t              stored_addrs [$];
    logic [PC_BITS-1:0] pc_model   = '0;
    logic               halt_model = 1'b0;

    out_t predicted_results [$];
    int   fail_count = 0;
    int   cycles     = 0;

    // sender and receiver idling controls
    logic     bursty      = 1'b0;
    int       burst_left  = 0;
    rx_mode_t rx_mode     = RX_ALWAYS;
    int       hold_req    = 0;
    int       hold_seen   = 0;
    int       hold_left   = 0;
    logic [15:0] ready_pattern = 16'hB79E;

    memory_to_memory_instruction_executor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("memory_to_memory_instruction_executor regression: fail");
            $finish;
        end
    end

    function automatic void store_word(input addr_t a, input word_t v);
        if (!word_valid[a])
        begin
            word_valid[a] = 1'b1;
            stored_addrs  = {stored_addrs, a};
        end
        mem_model[a] = v;
    endfunction

    // executes one request on the model and returns the status it reports
    function automatic out_t execute_instruction(input in_t req);
        out_t  res;
        addr_t ia;
        addr_t ib;
        word_t wa;
        logic  advance;
        ia      = req.operand_a[ADDR_BITS-1:0];
        ib      = req.operand_b[ADDR_BITS-1:0];
        res     = '0;
        advance = 1'b1;
        if (req.op == OP_LOAD)
            store_word(ib, word_t'(req.operand_a));
        else if (req.op == OP_READ)
            res.read_value = mem_model[ib];
        else if (req.op <= OP_HALT && !halt_model)
        begin
            case (req.op)
                OP_SET:       store_word(ib, word_t'(req.operand_a));
                OP_COPY:      store_word(ib, mem_model[ia]);
                OP_COPY_ISRC: store_word(ib, mem_model[mem_model[ia][ADDR_BITS-1:0]]);
                OP_ADD_IMM:   store_word(ib, mem_model[ib] + word_t'(req.operand_a));
                OP_ADD:       store_word(ib, mem_model[ib] + mem_model[ia]);
                OP_SUB:       store_word(ib, mem_model[ia] - mem_model[ib]);
                OP_JUMP_LE:
                begin
                    wa = mem_model[ia];
                    if (wa == '0 || wa[WORD_BITS-1])
                    begin
                        store_word(addr_t'(0), word_t'(req.operand_b));
                        pc_model = req.operand_b;
                        advance  = 1'b0;
                    end
                end
                OP_COPY_IDST: store_word(mem_model[ib][ADDR_BITS-1:0], mem_model[ia]);
                default:
                begin
                    halt_model = 1'b1;
                    advance    = 1'b0;
                end
            endcase
            if (advance)
                pc_model = pc_model + 1'b1;
        end
        res.next_pc = pc_model;
        res.halted  = halt_model;
        return res;
    endfunction

    function automatic in_t make_instr(input logic [3:0] op, input logic [OPA_BITS-1:0] a,
                                       input logic [OPB_BITS-1:0] b);
        in_t req;
        req.op        = op;
        req.operand_a = a;
        req.operand_b = b;
        return req;
    endfunction

    // mostly a small working set at both ends of memory, now and then anywhere
    function automatic addr_t pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return addr_t'($urandom_range(0, 31));
        if (r < 85)
            return addr_t'($urandom_range(MEM_WORDS - 32, MEM_WORDS - 1));
        return addr_t'($urandom());
    endfunction

    function automatic addr_t pick_stored();
        addr_t a;
        int    k;
        for (k = 0; k < 8; k++)
        begin
            a = pick_addr();
            if (word_valid[a])
                return a;
        end
        return stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
    endfunction

    // address operand with random upper bits, so negative addresses come up too
    function automatic logic [OPA_BITS-1:0] addr_operand(input addr_t a);
        logic [OPA_BITS-1:0] v;
        v = $urandom();
        v[ADDR_BITS-1:0] = a;
        return v;
    endfunction

    // small values double as pointers into the working set
    function automatic logic [OPA_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 31);
        if (r < 50)
            return -$urandom_range(1, 32);
        if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    // random instruction that only reads words already written
    function automatic in_t next_request();
        in_t   req;
        int    r;
        int    k;
        addr_t p;
        addr_t t;
        r   = $urandom_range(0, 99);
        req = make_instr(OP_READ, $urandom(), pick_stored());
        if (r < 12)
            req = make_instr(OP_LOAD, pick_value(), pick_addr());
        else if (r < 20)
            req = make_instr(OP_SET, pick_value(), pick_addr());
        else if (r < 30)
            req = make_instr(OP_COPY, addr_operand(pick_stored()), pick_addr());
        else if (r < 40)
        begin
            p = pick_stored();
            t = mem_model[p][ADDR_BITS-1:0];
            for (k = 0; k < 8 && !word_valid[t]; k++)
            begin
                p = pick_stored();
                t = mem_model[p][ADDR_BITS-1:0];
            end
            // pointer leads nowhere yet: fill its target first
            if (word_valid[t])
                req = make_instr(OP_COPY_ISRC, addr_operand(p), pick_addr());
            else
                req = make_instr(OP_LOAD, pick_value(), t);
        end
        else if (r < 50)
            req = make_instr(OP_ADD_IMM, pick_value(), pick_stored());
        else if (r < 60)
            req = make_instr(OP_ADD, addr_operand(pick_stored()), pick_stored());
        else if (r < 70)
            req = make_instr(OP_SUB, addr_operand(pick_stored()), pick_stored());
        else if (r < 80)
            req = make_instr(OP_JUMP_LE, addr_operand(pick_stored()), pick_addr());
        else if (r < 90)
            req = make_instr(OP_COPY_IDST, addr_operand(pick_stored()), pick_stored());
        else if (r >= 97)
            req = make_instr(4'($urandom_range(OP_READ + 1, 15)),
                             addr_operand(pick_stored()), pick_stored());
        return req;
    endfunction

    task automatic issue_request(input in_t req);
        int gap;
        gap = 0;
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_results = {predicted_results, execute_instruction(req)};
    endtask

    always @(posedge clk)
    begin
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_RANDOM:  out_ready <= ($urandom_range(0, 99) >= 30);
                RX_PATTERN: out_ready <= ready_pattern[0];
                default:    out_ready <= 1'b1;
            endcase
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("unexpected result", '0, out_data.read_value);
            else
            begin
                want = predicted_results.pop_front();
                if (out_data.next_pc !== want.next_pc)
                    report_mismatch("next_pc", 32'(want.next_pc), 32'(out_data.next_pc));
                if (out_data.halted !== want.halted)
                    report_mismatch("halted", 32'(want.halted), 32'(out_data.halted));
                if (out_data.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, out_data.read_value);
            end
        end
    end

    task automatic test_directed();
        int op;
        bursty  = 1'b0;
        rx_mode = RX_ALWAYS;
        issue_request(make_instr(OP_LOAD, 32'h8000_0000, 10'd0));
        issue_request(make_instr(OP_LOAD, 32'h7FFF_FFFF, 10'd1023));
        issue_request(make_instr(OP_SET, 32'd5, 10'd1));
        issue_request(make_instr(OP_SET, 32'hFFFF_FFFF, 10'd5));
        // source address -1 wraps to the top word
        issue_request(make_instr(OP_COPY, 32'hFFFF_FFFF, 10'd2));
        issue_request(make_instr(OP_COPY_ISRC, 32'd1, 10'd3));
        issue_request(make_instr(OP_ADD_IMM, 32'h7FFF_FFFF, 10'd2));
        issue_request(make_instr(OP_ADD, 32'd1023, 10'd0));
        issue_request(make_instr(OP_SUB, 32'd1, 10'd3));
        issue_request(make_instr(OP_COPY_IDST, 32'd2, 10'd1));
        issue_request(make_instr(OP_JUMP_LE, 32'd1, 10'd100));
        issue_request(make_instr(OP_SET, 32'd0, 10'd4));
        // taken on zero, then the next instruction wraps the counter
        issue_request(make_instr(OP_JUMP_LE, 32'd4, 10'd1023));
        issue_request(make_instr(OP_SET, 32'h5A5A_A5A5, 10'd6));
        issue_request(make_instr(OP_JUMP_LE, 32'd5, 10'h155));
        for (op = OP_READ + 1; op <= 15; op++)
            issue_request(make_instr(4'(op), 32'd1, 10'd1));
        // pointer -1 in a word sends the write to the top
        issue_request(make_instr(OP_LOAD, 32'hFFFF_FFFF, 10'd7));
        issue_request(make_instr(OP_COPY_IDST, 32'd6, 10'd7));
        issue_request(make_instr(OP_READ, 32'hFFFF_FFFF, 10'd1023));
        issue_request(make_instr(OP_READ, 32'd0, 10'd0));
        issue_request(make_instr(OP_READ, 32'h8000_0000, 10'd5));
    endtask

    task automatic test_random_programs();
        int i;
        bursty  = 1'b0;
        rx_mode = RX_ALWAYS;
        for (i = 0; i < 150; i++)
            issue_request(next_request());
        bursty  = 1'b1;
        rx_mode = RX_RANDOM;
        for (i = 0; i < 250; i++)
            issue_request(next_request());
        rx_mode = RX_PATTERN;
        for (i = 0; i < 250; i++)
            issue_request(next_request());
    endtask

    task automatic test_backpressure();
        int i;
        bursty   = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_req = hold_req + 1;
        for (i = 0; i < 40; i++)
            issue_request(next_request());
    endtask

    task automatic test_halt();
        int i;
        bursty  = 1'b1;
        rx_mode = RX_RANDOM;
        for (i = 0; i < 8; i++)
            issue_request(next_request());
        issue_request(make_instr(OP_HALT, $urandom(), 10'($urandom())));
        issue_request(make_instr(OP_JUMP_LE, addr_operand(pick_stored()), 10'd77));
        // executes are frozen now, load and read keep working
        for (i = 0; i < 16; i++)
        begin
            issue_request(next_request());
            issue_request(make_instr(OP_READ, $urandom(), pick_stored()));
        end
        issue_request(make_instr(OP_HALT, '0, '0));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_programs();
        test_backpressure();
        test_halt();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("memory_to_memory_instruction_executor regression: pass");
        else
            $display("memory_to_memory_instruction_executor regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mmie_pkg.sv
rtl/core/mmie_front.sv
rtl/core/mmie_fifo.sv
rtl/core/mmie_back.sv
rtl/core/memory_to_memory_instruction_executor.sv
rtl/core/mmie_checker.sv
sim/tb_memory_to_memory_instruction_executor.sv
